@@ rtl/hill_cipher_encrypt_macros.svh @@
// Assertion macros shared by the Hill cipher RTL.
`ifndef HILL_CIPHER_ENCRYPT_MACROS_SVH
`define HILL_CIPHER_ENCRYPT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define HCE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hill cipher assertion failed");

// Next-cycle implication, checked outside reset.
`define HCE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hill cipher assertion failed");

`endif

@@ rtl/hce_pkg.sv @@
// Types and constants shared by the Hill cipher encryption block.
package hce_pkg;

    localparam int KEY_ROWS    = 4;
    localparam int LETTER_W    = 5;
    localparam int N_W         = 3;
    localparam int ROW_W       = 2;
    localparam int KEY_W       = KEY_ROWS * LETTER_W;
    localparam int CFG_IDX_W   = 3;
    localparam int PROD_W      = 2 * LETTER_W;
    localparam int SUM_W       = PROD_W + 2;
    localparam int RECIP_W     = 14;
    localparam int QMUL_W      = SUM_W + RECIP_W;
    localparam int RECIP_SHIFT = 18;
    localparam int QUOT_W      = 8;
    localparam int QUEUE_DEPTH = 2;

    // floor(s / 26) == (s * 10083) >> 18 for every s below 2**12
    localparam logic [RECIP_W-1:0]  RECIP   = 14'd10083;
    localparam logic [LETTER_W-1:0] LETTERS = 5'd26;

    localparam logic [CFG_IDX_W-1:0] CFG_KEY_ROW_0  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_ROW_1  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_ROW_2  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_ROW_3  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE = 3'd4;

    typedef logic [LETTER_W-1:0] letter_t;
    typedef logic [N_W-1:0]      count_t;
    typedef logic [KEY_ROWS-1:0][LETTER_W-1:0] key_row_t;
    typedef key_row_t [KEY_ROWS-1:0] key_matrix_t;

    // One complete plaintext block and the size it was collected with
    typedef struct packed {
        key_row_t letters;
        count_t   n;
    } block_t;

    // Head of the block queue as the back end sees it
    typedef struct packed {
        logic   valid;
        block_t blk;
    } queue_head_t;

endpackage

@@ rtl/hce_front.sv @@
// Front end: collects plaintext letters into blocks and pushes full blocks.
module hce_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic [4:0]      plain_letter,
    input  logic            in_valid,
    output logic            in_ready,
    input  hce_pkg::count_t n,
    output logic            push_valid,
    output hce_pkg::block_t push_blk,
    input  logic            push_ready
);
    import hce_pkg::*;

    key_row_t              buf_reg;
    key_row_t              buf_next;
    logic [ROW_W-1:0]      fill_reg;
    logic [ROW_W-1:0]      fill_next;
    count_t                fill_inc;
    logic                  accept;
    logic                  complete;

    assign in_ready = push_ready;
    assign accept   = in_valid && in_ready;
    assign fill_inc = N_W'(fill_reg) + N_W'(1);
    assign complete = (fill_inc >= n);

    always_comb
    begin
        buf_next           = buf_reg;
        buf_next[fill_reg] = plain_letter;
        fill_next          = fill_reg;
        if (accept)
        begin
            fill_next = complete ? '0 : fill_inc[ROW_W-1:0];
        end
    end

    assign push_valid       = accept && complete;
    assign push_blk.letters = buf_next;
    assign push_blk.n       = n;

    // Letter store has no reset; entries are written before use
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            buf_reg <= buf_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
        end
    end

endmodule

@@ rtl/hce_queue.sv @@
// Short block queue between the front and back ends.
`include "hill_cipher_encrypt_macros.svh"
module hce_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push_valid,
    input  hce_pkg::block_t     push_blk,
    output logic                push_ready,
    output hce_pkg::queue_head_t head,
    input  logic                pop
);
    import hce_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

    block_t              entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg;
    logic [PTR_W-1:0]    wr_ptr_next;
    logic [PTR_W-1:0]    rd_ptr_reg;
    logic [PTR_W-1:0]    rd_ptr_next;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic                push;

    assign push_ready = (count_reg != FULL_CNT);
    assign push       = push_valid && push_ready;
    assign head.valid = (count_reg != '0);
    assign head.blk   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_blk;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `HCE_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, count_reg <= FULL_CNT)
    `HCE_ASSERT_NOW(a_no_pop_empty, clk, rst_n, pop, count_reg != '0)
    `HCE_ASSERT_NEXT(a_push_counts, clk, rst_n, push && !pop, count_reg == $past(count_reg) + CNT_W'(1))

endmodule

@@ rtl/hce_back.sv @@
// Back end: per-row dot product, mod 26 reduction and output register.
`include "hill_cipher_encrypt_macros.svh"
module hce_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  hce_pkg::key_matrix_t key,
    input  hce_pkg::queue_head_t head,
    output logic                 pop,
    output logic [4:0]           cipher_letter,
    output logic                 last_of_block,
    output logic                 out_valid,
    input  logic                 out_ready
);
    import hce_pkg::*;

    logic [ROW_W-1:0]  row_reg;
    logic [ROW_W-1:0]  row_next;
    logic              issue;
    logic              row_last;

    logic              a_valid_reg;
    logic [SUM_W-1:0]  a_sum_reg;
    logic [SUM_W-1:0]  a_sum_next;
    logic              a_last_reg;
    logic              a_free;

    logic              b_valid_reg;
    logic [SUM_W-1:0]  b_sum_reg;
    logic [QUOT_W-1:0] b_quot_reg;
    logic [QUOT_W-1:0] b_quot_next;
    logic [QMUL_W-1:0] quot_prod;
    logic              b_last_reg;
    logic              b_free;

    logic              out_valid_reg;
    letter_t           out_letter_reg;
    logic              out_last_reg;
    logic [SUM_W-1:0]  rem_full;
    logic              out_adv;

    assign out_adv = !out_valid_reg || out_ready;
    assign b_free  = !b_valid_reg || out_adv;
    assign a_free  = !a_valid_reg || b_free;

    assign row_last = (N_W'(row_reg) == head.blk.n - N_W'(1));
    assign issue    = head.valid && a_free;
    assign pop      = issue && row_last;
    assign row_next = issue ? (row_last ? '0 : row_reg + ROW_W'(1)) : row_reg;

    // Row dot product; columns past n contribute nothing
    always_comb
    begin
        a_sum_next = '0;
        for (int j = 0; j < KEY_ROWS; j++)
        begin
            if (N_W'(j) < head.blk.n)
            begin
                a_sum_next = a_sum_next + SUM_W'(PROD_W'(key[row_reg][j])
                                                * PROD_W'(head.blk.letters[j]));
            end
        end
    end

    // Quotient by reciprocal multiply, exact over the sum range
    assign quot_prod   = QMUL_W'(a_sum_reg) * QMUL_W'(RECIP);
    assign b_quot_next = quot_prod[RECIP_SHIFT +: QUOT_W];

    // sum - 26 * quotient, 26 = 16 + 8 + 2
    assign rem_full = b_sum_reg - (SUM_W'(b_quot_reg) << 4) - (SUM_W'(b_quot_reg) << 3)
                    - (SUM_W'(b_quot_reg) << 1);

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            a_sum_reg  <= a_sum_next;
            a_last_reg <= row_last;
        end
        if (a_valid_reg && b_free)
        begin
            b_sum_reg  <= a_sum_reg;
            b_quot_reg <= b_quot_next;
            b_last_reg <= a_last_reg;
        end
        if (b_valid_reg && out_adv)
        begin
            out_letter_reg <= rem_full[LETTER_W-1:0];
            out_last_reg   <= b_last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg       <= '0;
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            row_reg <= row_next;
            if (a_free)
            begin
                a_valid_reg <= issue;
            end
            if (b_free)
            begin
                b_valid_reg <= a_valid_reg;
            end
            if (out_adv)
            begin
                out_valid_reg <= b_valid_reg;
            end
        end
    end

    assign cipher_letter = out_letter_reg;
    assign last_of_block = out_last_reg;
    assign out_valid     = out_valid_reg;

    `HCE_ASSERT_NOW(a_rem_in_range, clk, rst_n, b_valid_reg, rem_full < SUM_W'(LETTERS))
    `HCE_ASSERT_NOW(a_row_below_n, clk, rst_n, head.valid, N_W'(row_reg) < head.blk.n)

endmodule

@@ rtl/hill_cipher_encrypt.sv @@
// Top level of the Hill cipher encryption block.
//
//  channel      | dir | handshake             | payload
//  -------------+-----+-----------------------+------------------------------
//  plaintext    | in  | in_valid / in_ready   | plain_letter[4:0]
//  ciphertext   | out | out_valid / out_ready | cipher_letter[4:0], last_of_block
//  config write | in  | cfg_write             | cfg_index[2:0], cfg_data[19:0]
//
// Sustains one plaintext letter per cycle in and one cipher letter per cycle out
// while the output is not stalled. A completed block enters a 2-entry block queue;
// the back end drains one key row per cycle while the output advances. Once a block's
// last letter is accepted, its cipher letters pass from the queue through the dot
// product and quotient registers to the remainder held in the output register.
// Reset clears the key to the identity, block size to 4 and all control state;
// no clearing pass. Output stalls back up through the pipeline and the queue,
// and in_ready falls only while the block queue is full.
module hill_cipher_encrypt #(
    parameter int MAX_BLOCK = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic [4:0]  plain_letter,
    input  logic        in_valid,
    output logic        in_ready,
    output logic [4:0]  cipher_letter,
    output logic        last_of_block,
    output logic        out_valid,
    input  logic        out_ready,
    input  logic        cfg_write,
    input  logic [2:0]  cfg_index,
    input  logic [19:0] cfg_data
);
    import hce_pkg::*;

    // largest usable block: bounded by the four key rows
    localparam int     CAP_INT = (MAX_BLOCK < KEY_ROWS) ? MAX_BLOCK : KEY_ROWS;
    localparam count_t CAP_N   = N_W'(CAP_INT);

    key_matrix_t  key_reg;
    count_t       block_size_reg;
    count_t       eff_n;

    logic         push_valid;
    logic         push_ready;
    block_t       push_blk;
    queue_head_t  head;
    logic         pop;

    // config registers, writes to unknown indexes drop
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg[0]     <= KEY_W'(1);
            key_reg[1]     <= KEY_W'(32);
            key_reg[2]     <= KEY_W'(1024);
            key_reg[3]     <= KEY_W'(32768);
            block_size_reg <= N_W'(4);
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_KEY_ROW_0:  key_reg[0]     <= cfg_data;
                CFG_KEY_ROW_1:  key_reg[1]     <= cfg_data;
                CFG_KEY_ROW_2:  key_reg[2]     <= cfg_data;
                CFG_KEY_ROW_3:  key_reg[3]     <= cfg_data;
                CFG_BLOCK_SIZE: block_size_reg <= cfg_data[N_W-1:0];
                default:        ;
            endcase
        end
    end

    // zero size acts as 1, oversize saturates to the cap
    always_comb
    begin
        if (block_size_reg == '0)
        begin
            eff_n = N_W'(1);
        end
        else if (block_size_reg > CAP_N)
        begin
            eff_n = CAP_N;
        end
        else
        begin
            eff_n = block_size_reg;
        end
    end

    hce_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .plain_letter (plain_letter),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .n            (eff_n),
        .push_valid   (push_valid),
        .push_blk     (push_blk),
        .push_ready   (push_ready)
    );

    hce_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_blk   (push_blk),
        .push_ready (push_ready),
        .head       (head),
        .pop        (pop)
    );

    hce_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .key           (key_reg),
        .head          (head),
        .pop           (pop),
        .cipher_letter (cipher_letter),
        .last_of_block (last_of_block),
        .out_valid     (out_valid),
        .out_ready     (out_ready)
    );

endmodule

@@ bench/hill_cipher_encrypt_tb.sv @@
`timescale 1ns / 1ps
// Self-checking bench for hill_cipher_encrypt: letter stream in, predicted cipher letters out.
module hill_cipher_encrypt_tb;

    import hce_pkg::*;

    localparam int MAX_BLOCK = 4;
    // Widest block the key can serve: four rows, and no more than MAX_BLOCK
    localparam int N_CAP = (MAX_BLOCK < KEY_ROWS) ? MAX_BLOCK : KEY_ROWS;
    // Register indexes past the end of the list; writes there must be dropped
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;
    // Cycles allowed after the last cipher letter before the block counts as quiet
    localparam int GUARD_CYCLES = 12;
    localparam int IDLE_PCT = 23;
    localparam int RANDOM_ITEMS = 394;

    // One cipher letter as it should appear on the output port
    typedef struct packed {
        letter_t letter;
        logic    last;
    } cipher_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic [4:0]        plain_letter = '0;
    logic              in_valid = 1'b0;
    logic              in_ready;
    logic [4:0]        cipher_letter;
    logic              last_of_block;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic              cfg_write = 1'b0;
    logic [2:0]        cfg_index = '0;
    logic [19:0]       cfg_data = '0;

    // Plaintext letters waiting to be offered, and cipher letters still owed
    letter_t           plain_queue[$];
    cipher_t           cipher_due[$];
    cipher_t           due_head;
    int                errors = 0;
    // Set for a stretch in which neither side idles
    logic              steady = 1'b0;

    // Shadow copy of the block's key, block size and collection buffer
    logic [KEY_W-1:0]  key_reg [KEY_ROWS];
    logic [N_W-1:0]    block_sz;
    letter_t           letter_buf [KEY_ROWS];
    count_t            fill_cnt;

    hill_cipher_encrypt #(
        .MAX_BLOCK(MAX_BLOCK)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .plain_letter(plain_letter),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .cipher_letter(cipher_letter),
        .last_of_block(last_of_block),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // Run-away guard, sized well past the slowest legal run
    initial
    begin
        #400000;
        $display("CHECK FAILED");
        $finish;
    end

    // Buffer one accepted letter; once the block is full, owe one cipher
    // letter per key row in use, each the row's dot product with the block mod 26.
    task automatic encrypt_letter(input letter_t letter);
        int n;
        int acc;
        cipher_t c;
        n = (block_sz == 0) ? 1 : (block_sz > N_CAP) ? N_CAP : int'(block_sz);
        letter_buf[fill_cnt[1:0]] = letter;
        fill_cnt = fill_cnt + 1'b1;
        if (fill_cnt >= n)
        begin
            for (int i = 0; i < n; i++)
            begin
                acc = 0;
                for (int j = 0; j < n; j++)
                    acc = (acc + key_reg[i][LETTER_W*j +: LETTER_W] * letter_buf[j])
                          % int'(LETTERS);
                c.letter = letter_t'(acc);
                c.last = (i == n - 1);
                cipher_due.push_back(c);
            end
            fill_cnt = '0;
        end
    endtask

    // One register write; the shadow copy follows it, spare indexes change nothing
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [KEY_W-1:0] data);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        if (idx < KEY_ROWS)
            key_reg[idx[ROW_W-1:0]] = data;
        else if (idx == CFG_BLOCK_SIZE)
            block_sz = data[N_W-1:0];
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    // Hold off until every letter is in and every owed cipher letter is out,
    // then give the pipeline its latency plus slack before touching config.
    // Checked between edges so the driver's and monitor's updates have settled.
    task automatic drain();
        while (plain_queue.size() != 0 || in_valid || cipher_due.size() != 0)
            @(negedge clk);
        repeat (GUARD_CYCLES) @(posedge clk);
    endtask

    // Driver: offers queued letters, holding each until the handshake takes it.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            plain_letter <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
                encrypt_letter(plain_letter);
            if (!in_valid || in_ready)
            begin
                if (plain_queue.size() != 0 && (steady || $urandom_range(0, 99) >= IDLE_PCT))
                begin
                    in_valid <= 1'b1;
                    plain_letter <= plain_queue.pop_front();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: random back-pressure, and each cipher transaction is checked
    // field by field against the oldest owed letter.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
            if (out_valid && out_ready)
            begin
                if (cipher_due.size() == 0)
                begin
                    $display("%0t: unexpected cipher transaction: expected none, got %0d last %0b",
                             $time, cipher_letter, last_of_block);
                    errors++;
                end
                else
                begin
                    due_head = cipher_due.pop_front();
                    if (cipher_letter !== due_head.letter)
                    begin
                        $display("%0t: cipher_letter mismatch: expected %0d, got %0d",
                                 $time, due_head.letter, cipher_letter);
                        errors++;
                    end
                    if (last_of_block !== due_head.last)
                    begin
                        $display("%0t: last_of_block mismatch: expected %0b, got %0b",
                                 $time, due_head.last, last_of_block);
                        errors++;
                    end
                end
            end
        end
    end

    // Stimulus: directed corners, then random phases with config changes
    // between them. Each phase ends with the sender paused until all owed
    // cipher letters have come back.
    initial
    begin
        int sent;
        int count;
        int pick;
        logic [KEY_W-1:0] row;

        // Reset state: identity key, blocks of four
        key_reg[0] = 20'd1;
        key_reg[1] = 20'd32;
        key_reg[2] = 20'd1024;
        key_reg[3] = 20'd32768;
        block_sz = 3'd4;
        fill_cnt = '0;
        for (int k = 0; k < KEY_ROWS; k++)
            letter_buf[k] = '0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Identity key straight out of reset, letters at the ends of the
        // range and past 'z' (those must reduce mod 26)
        plain_queue = '{5'd0, 5'd25, 5'd26, 5'd31, 5'd13, 5'd7, 5'd1, 5'd30};
        drain();

        // Every key entry at 31: exercises the mod reduction of key entries
        for (int k = 0; k < KEY_ROWS; k++)
            write_reg(CFG_IDX_W'(CFG_KEY_ROW_0 + k), 20'hFFFFF);
        plain_queue = '{5'd25, 5'd31, 5'd0, 5'd17};
        drain();

        // Block size zero acts as one; all-zero key row 0
        write_reg(CFG_KEY_ROW_0, 20'h00000);
        write_reg(CFG_BLOCK_SIZE, 20'd0);
        plain_queue = '{5'd31, 5'd5};
        drain();
        write_reg(CFG_KEY_ROW_0, {5'd25, 5'd24, 5'd3, 5'd25});
        plain_queue = '{5'd25};
        drain();

        // Block size past the top saturates at four; spare indexes ignored
        write_reg(CFG_BLOCK_SIZE, 20'hFFFFF);
        for (int k = CFG_SPARE_LO; k <= CFG_SPARE_HI; k++)
            write_reg(CFG_IDX_W'(k), 20'hFFFFF);
        plain_queue = '{5'd3, 5'd14, 5'd15, 5'd9};
        drain();

        // Shrinking the block size with letters already buffered: the next
        // letter emits a block at once from the oldest buffered letters
        write_reg(CFG_BLOCK_SIZE, 20'd3);
        plain_queue = '{5'd11, 5'd22};
        drain();
        write_reg(CFG_BLOCK_SIZE, 20'd1);
        plain_queue = '{5'd6};
        drain();
        write_reg(CFG_BLOCK_SIZE, 20'd4);
        plain_queue = '{5'd19, 5'd2, 5'd28};
        drain();
        write_reg(CFG_BLOCK_SIZE, 20'd2);
        plain_queue = '{5'd8};
        drain();

        // Random phases: new key and size settings, then a burst of letters.
        // The first burst runs with no idling on either side.
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            for (int k = 0; k < KEY_ROWS; k++)
            begin
                if ($urandom_range(0, 1) == 1)
                begin
                    if ($urandom_range(0, 7) == 0)
                        row = KEY_W'($urandom);
                    else
                        for (int j = 0; j < KEY_ROWS; j++)
                            row[LETTER_W*j +: LETTER_W] = letter_t'($urandom_range(0, 25));
                    write_reg(CFG_IDX_W'(CFG_KEY_ROW_0 + k), row);
                end
            end
            if ($urandom_range(0, 1) == 1)
            begin
                pick = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 4) : $urandom_range(0, 7);
                write_reg(CFG_BLOCK_SIZE, {17'($urandom), 3'(pick)});
            end
            if ($urandom_range(0, 9) == 0)
                write_reg(CFG_IDX_W'($urandom_range(CFG_SPARE_LO, CFG_SPARE_HI)),
                          KEY_W'($urandom));

            steady = (sent == 0);
            count = steady ? 80 : $urandom_range(8, 48);
            if (count > RANDOM_ITEMS - sent)
                count = RANDOM_ITEMS - sent;
            for (int k = 0; k < count; k++)
                plain_queue.push_back(($urandom_range(0, 7) == 0) ?
                                      letter_t'($urandom_range(0, 31)) :
                                      letter_t'($urandom_range(0, 25)));
            sent += count;
            drain();
            steady = 1'b0;
        end

        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
